FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and constants for the sorted-insert priority queue cells
// and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W = 32;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic signed [DATA_W-1:0] value;
    } spq_ctrl_t;

endpackage

FILE: hw/rtl/sorted_insert_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted-insert priority queue core
// A row of DEPTH cells keeps the stored values in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, kind, value) carries one push or
// pop per transaction. The output channel (out_valid, out_stall, min_value,
// max_value, is_empty, is_full, status) returns one result transaction for
// every input transaction, in order.
// The result is loaded into the output register at the edge that accepts
// the input transaction and is offered in the next cycle. Throughput is
// one transaction per cycle while the receiver does not stall a waiting
// result, because every cell compares the incoming value with its own entry
// in parallel and the whole row shifts by at most one place per cycle.
// Equal values leave in arrival order. A pop on an empty queue and a push
// on a full queue change nothing and are flagged in status.
// Reset empties the queue and clears the output valid flag; the stored
// entries themselves are not cleared. While the receiver stalls a waiting
// result, in_stall is raised and no new transaction is taken.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] min_value,
    output logic signed [DATA_W-1:0] max_value,
    output logic                     is_empty,
    output logic                     is_full,
    output logic [1:0]               status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]         occupancy_reg;
    logic [CNT_W-1:0]         occupancy_next;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] max_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] min_value_reg;
    logic signed [DATA_W-1:0] max_value_reg;
    logic                     is_empty_reg;
    logic                     is_full_reg;
    spq_status_t              status_reg;
    spq_status_t              status_next;

    logic                     in_fire;
    logic                     cur_empty;
    logic                     cur_full;
    spq_ctrl_t                ctrl;

    logic                     lt_vec    [DEPTH];
    logic signed [DATA_W-1:0] entries   [DEPTH];
    logic signed [DATA_W-1:0] nexts     [DEPTH];

    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign cur_empty = (occupancy_reg == '0);
    assign cur_full  = (occupancy_reg == CNT_W'(DEPTH));

    assign ctrl.push  = in_fire && (kind == KIND_PUSH) && !cur_full;
    assign ctrl.pop   = in_fire && (kind == KIND_POP) && !cur_empty;
    assign ctrl.value = value;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                     left_lt;
            logic signed [DATA_W-1:0] left_entry;
            logic signed [DATA_W-1:0] right_entry;

            if (g == 0)
            begin : g_first
                assign left_lt    = 1'b0;
                assign left_entry = entries[g];
            end
            else
            begin : g_mid
                assign left_lt    = lt_vec[g-1];
                assign left_entry = entries[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_entry = entries[g];
            end
            else
            begin : g_inner
                assign right_entry = entries[g+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupancy_reg > CNT_W'(g)),
                .left_lt     (left_lt),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .lt          (lt_vec[g]),
                .entry       (entries[g]),
                .entry_next  (nexts[g])
            );
        end
    endgenerate

    always_comb
    begin
        occupancy_next = occupancy_reg;
        max_next       = max_reg;
        status_next    = ST_DONE;
        if (in_fire)
        begin
            if (kind == KIND_PUSH)
            begin
                if (cur_full)
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    occupancy_next = occupancy_reg + CNT_W'(1);
                    if (cur_empty || (value >= max_reg))
                    begin
                        max_next = value;
                    end
                end
            end
            else
            begin
                if (cur_empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    occupancy_next = occupancy_reg - CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occupancy_reg <= occupancy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        if (in_fire)
        begin
            if (occupancy_next == '0)
            begin
                min_value_reg <= '0;
                max_value_reg <= '0;
            end
            else
            begin
                min_value_reg <= nexts[0];
                max_value_reg <= max_next;
            end
            is_empty_reg <= (occupancy_next == '0);
            is_full_reg  <= (occupancy_next == CNT_W'(DEPTH));
            status_reg   <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_value = min_value_reg;
    assign max_value = max_value_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;
    assign status    = status_reg;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= CNT_W'(DEPTH))
        else $error("Occupancy exceeds the queue depth.");

    a_drop_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind == KIND_PUSH) && cur_full) |=> $stable(occupancy_reg))
        else $error("A dropped push changed the occupancy.");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> ((min_value == '0) && (max_value == '0)))
        else $error("An empty result reports nonzero extremes.");

    a_pop_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_POP_EMPTY)) |-> is_empty)
        else $error("A pop on empty reported a nonempty queue.");

    a_push_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_PUSH_FULL)) |-> is_full)
        else $error("A dropped push reported a queue that is not full.");
`endif

endmodule

FILE: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the ascending chain. On a push it keeps its entry,
// takes the new value, or takes its left neighbor's entry; on a pop it
// takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                     clk,
    input  spq_ctrl_t                ctrl,
    input  logic                     occupied,
    input  logic                     left_lt,
    input  logic signed [DATA_W-1:0] left_entry,
    input  logic signed [DATA_W-1:0] right_entry,
    output logic                     lt,
    output logic signed [DATA_W-1:0] entry,
    output logic signed [DATA_W-1:0] entry_next
);

    logic signed [DATA_W-1:0] entry_reg;

    assign lt    = occupied && (ctrl.value < entry_reg);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (left_lt)
            begin
                entry_next = left_entry;
            end
            else if (lt || !occupied)
            begin
                entry_next = ctrl.value;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
